@@ rtl/abac_pkg.sv @@
package abac_pkg;

    localparam int SAMPLE_W = 10;
    localparam int AXIS_W   = 2;
    localparam int CFG_W    = 10;
    localparam int CENTI_W  = 19;
    localparam int NUM_W    = 18;
    localparam int DEN_W    = 10;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;
    localparam int NUM_AXES = 3;

    localparam int CENTI_SCALE = 100;
    localparam int CENTI_LIMIT = 204600;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] REG_X_LOW  = 3'd0;
    localparam logic [2:0] REG_X_HIGH = 3'd1;
    localparam logic [2:0] REG_Y_LOW  = 3'd2;
    localparam logic [2:0] REG_Y_HIGH = 3'd3;
    localparam logic [2:0] REG_Z_LOW  = 3'd4;
    localparam logic [2:0] REG_Z_HIGH = 3'd5;

    localparam logic [CFG_W-1:0] X_LOW_RST  = 10'd249;
    localparam logic [CFG_W-1:0] X_HIGH_RST = 10'd727;
    localparam logic [CFG_W-1:0] Y_LOW_RST  = 10'd249;
    localparam logic [CFG_W-1:0] Y_HIGH_RST = 10'd727;
    localparam logic [CFG_W-1:0] Z_LOW_RST  = 10'd307;
    localparam logic [CFG_W-1:0] Z_HIGH_RST = 10'd705;

    typedef logic [NUM_AXES-1:0][CFG_W-1:0] cal_points_t;

    typedef struct packed {
        logic capture;
        logic accum;
        logic avg_start;
        logic avg_load;
        logic cal_start;
        logic out_load;
    } abac_cmd_t;

    typedef struct packed {
        logic axis_bad;
        logic block_full;
        logic den_zero;
        logic div_done;
        logic div_busy;
        logic out_free;
    } abac_stat_t;

endpackage

@@ rtl/abac_div.sv @@
module abac_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [abac_pkg::NUM_W-1:0]  dividend,
    input  logic [abac_pkg::DEN_W-1:0]  divisor,
    output logic [abac_pkg::NUM_W-1:0]  quotient,
    output logic                        done,
    output logic                        busy
);
    import abac_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;

    // one quotient bit per cycle, msb first
    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DEN_W+1]) begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
    assign busy     = busy_reg;

endmodule

@@ rtl/abac_dp.sv @@
module abac_dp #(
    parameter int AVERAGE_LEN = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  abac_pkg::abac_cmd_t                 cmd,
    output abac_pkg::abac_stat_t                stat,
    input  logic [abac_pkg::AXIS_W-1:0]         in_axis,
    input  logic [abac_pkg::SAMPLE_W-1:0]       in_sample,
    input  abac_pkg::cal_points_t               low_pts,
    input  abac_pkg::cal_points_t               high_pts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [abac_pkg::AXIS_W-1:0]         out_axis,
    output logic [abac_pkg::SAMPLE_W-1:0]       out_average,
    output logic signed [abac_pkg::CENTI_W-1:0] out_centi_g,
    output logic                                out_updated,
    output logic                                out_error
);
    import abac_pkg::*;

    localparam int CNT_W  = $clog2(AVERAGE_LEN + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int USE_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int DIFF_W = CFG_W + 3;
    localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((1 << USE_W) - 1);

    logic [SUM_W-1:0]    sum_reg   [NUM_AXES];
    logic [CNT_W-1:0]    count_reg [NUM_AXES];
    logic [SAMPLE_W-1:0] held_reg  [NUM_AXES];

    logic [AXIS_W-1:0]   axis_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic                upd_reg;
    logic                zero_reg;
    logic                neg_reg;

    logic                   m_valid_reg;
    logic [AXIS_W-1:0]      m_axis_reg;
    logic [SAMPLE_W-1:0]    m_avg_reg;
    logic [CENTI_W-1:0]     m_centi_reg;
    logic                   m_upd_reg;
    logic                   m_err_reg;

    logic [SAMPLE_W-1:0]       cur_avg;
    logic [CFG_W-1:0]          cur_low;
    logic [CFG_W-1:0]          cur_high;
    logic signed [CFG_W:0]     den_s;
    logic signed [DIFF_W-1:0]  diff_s;
    logic signed [CENTI_W-1:0] num_s;
    logic [NUM_W-1:0]          num_mag;
    logic [DEN_W-1:0]          den_mag;
    logic                      den_zero;

    logic              div_start;
    logic [NUM_W-1:0]  div_dividend;
    logic [DEN_W-1:0]  div_divisor;
    logic [NUM_W-1:0]  div_quo;
    logic              div_done;
    logic              div_busy;
    logic [CENTI_W-1:0] q_ext;

    // calibration arithmetic on the selected axis
    always_comb begin
        cur_avg  = held_reg[axis_reg];
        cur_low  = low_pts[axis_reg];
        cur_high = high_pts[axis_reg];
        den_s    = $signed({1'b0, cur_high}) - $signed({1'b0, cur_low});
        diff_s   = $signed({2'b0, cur_avg, 1'b0}) - $signed({3'b0, cur_high})
                   - $signed({3'b0, cur_low});
        num_s    = diff_s * $signed(CENTI_W'(CENTI_SCALE));
        num_mag  = num_s[CENTI_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
        den_mag  = den_s[CFG_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
        den_zero = (den_s == '0);
    end

    always_comb begin
        div_start    = cmd.avg_start | (cmd.cal_start & !den_zero);
        div_dividend = cmd.avg_start ? NUM_W'(sum_reg[axis_reg]) : num_mag;
        div_divisor  = cmd.avg_start ? DEN_W'(AVERAGE_LEN) : den_mag;
    end

    abac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done),
        .busy     (div_busy)
    );

    assign q_ext = {1'b0, div_quo};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
                held_reg[i]  <= '0;
            end
            m_valid_reg <= 1'b0;
            upd_reg     <= 1'b0;
        end else begin
            if (cmd.accum) begin
                if (held_reg[axis_reg] == '0) begin
                    held_reg[axis_reg] <= smp_reg;
                end
                sum_reg[axis_reg]   <= sum_reg[axis_reg] + SUM_W'(smp_reg);
                count_reg[axis_reg] <= count_reg[axis_reg] + 1'b1;
            end
            if (cmd.avg_load) begin
                held_reg[axis_reg]  <= div_quo[SAMPLE_W-1:0];
                sum_reg[axis_reg]   <= '0;
                count_reg[axis_reg] <= '0;
            end
            if (cmd.capture) begin
                upd_reg <= 1'b0;
            end else if (cmd.avg_load) begin
                upd_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.capture) begin
            axis_reg <= in_axis;
            smp_reg  <= in_sample & SMP_MASK;
        end
        if (cmd.cal_start) begin
            zero_reg <= den_zero;
            neg_reg  <= num_s[CENTI_W-1] ^ den_s[CFG_W];
        end
        if (cmd.out_load) begin
            m_axis_reg  <= axis_reg;
            m_avg_reg   <= cur_avg;
            m_upd_reg   <= upd_reg;
            m_err_reg   <= zero_reg;
            if (zero_reg) begin
                m_centi_reg <= '0;
            end else if (neg_reg) begin
                m_centi_reg <= -q_ext;
            end else begin
                m_centi_reg <= q_ext;
            end
        end
    end

    always_comb begin
        stat.axis_bad   = (axis_reg != AXIS_X) && (axis_reg != AXIS_Y) && (axis_reg != AXIS_Z);
        stat.block_full = (count_reg[axis_reg] >= CNT_W'(AVERAGE_LEN));
        stat.den_zero   = den_zero;
        stat.div_done   = div_done;
        stat.div_busy   = div_busy;
        stat.out_free   = !m_valid_reg || m_tready;
    end

    assign m_tvalid    = m_valid_reg;
    assign out_axis    = m_axis_reg;
    assign out_average = m_avg_reg;
    assign out_centi_g = $signed(m_centi_reg);
    assign out_updated = m_upd_reg;
    assign out_error   = m_err_reg;

endmodule

@@ rtl/abac_ctrl.sv @@
module abac_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  abac_pkg::abac_stat_t stat,
    output abac_pkg::abac_cmd_t  cmd
);
    import abac_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_UPDATE  = 6'b000010,
        ST_DIV_AVG = 6'b000100,
        ST_CAL     = 6'b001000,
        ST_DIV_CAL = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (stat.axis_bad) begin
                    state_next = ST_IDLE;
                end else if (stat.block_full) begin
                    cmd.avg_start = 1'b1;
                    state_next    = ST_DIV_AVG;
                end else begin
                    cmd.accum  = 1'b1;
                    state_next = ST_CAL;
                end
            end
            ST_DIV_AVG: begin
                if (stat.div_done) begin
                    cmd.avg_load = 1'b1;
                    state_next   = ST_CAL;
                end
            end
            ST_CAL: begin
                cmd.cal_start = 1'b1;
                state_next    = stat.den_zero ? ST_FINISH : ST_DIV_CAL;
            end
            ST_DIV_CAL: begin
                if (stat.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/accel_block_average_calibrate.sv @@
// throughput: one item at a time; s_tready is high only in the idle state, so no new item
// is taken until the previous result is loaded for output. An item that closes a block
// runs the shared 18-step divider twice (block average, then calibration); the calibration
// divide is skipped when the axis high and low points are equal
// reset: aresetn synchronous active low; clears sums, counts and held averages,
// loads default calibration points
module accel_block_average_calibrate #(
    parameter int AVERAGE_LEN = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // sample
    input  logic [abac_pkg::AXIS_W-1:0]   s_tuser,   // axis_sel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // average, centi_g
    output logic [3:0]                    m_tuser,   // axis_out, avg_updated, cal_error
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abac_pkg::ADDR_W-1:0]   paddr,
    input  logic [abac_pkg::APB_W-1:0]    pwdata,
    output logic [abac_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import abac_pkg::*;

    cal_points_t low_reg;
    cal_points_t high_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    abac_cmd_t  dp_cmd;
    abac_stat_t dp_stat;

    logic [AXIS_W-1:0]         out_axis;
    logic [SAMPLE_W-1:0]       out_average;
    logic signed [CENTI_W-1:0] out_centi_g;
    logic                      out_updated;
    logic                      out_error;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg[0]  <= X_LOW_RST;
            high_reg[0] <= X_HIGH_RST;
            low_reg[1]  <= Y_LOW_RST;
            high_reg[1] <= Y_HIGH_RST;
            low_reg[2]  <= Z_LOW_RST;
            high_reg[2] <= Z_HIGH_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_X_LOW:  low_reg[0]  <= pwdata[CFG_W-1:0];
                REG_X_HIGH: high_reg[0] <= pwdata[CFG_W-1:0];
                REG_Y_LOW:  low_reg[1]  <= pwdata[CFG_W-1:0];
                REG_Y_HIGH: high_reg[1] <= pwdata[CFG_W-1:0];
                REG_Z_LOW:  low_reg[2]  <= pwdata[CFG_W-1:0];
                REG_Z_HIGH: high_reg[2] <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_X_LOW:  prdata = APB_W'(low_reg[0]);
            REG_X_HIGH: prdata = APB_W'(high_reg[0]);
            REG_Y_LOW:  prdata = APB_W'(low_reg[1]);
            REG_Y_HIGH: prdata = APB_W'(high_reg[1]);
            REG_Z_LOW:  prdata = APB_W'(low_reg[2]);
            REG_Z_HIGH: prdata = APB_W'(high_reg[2]);
            default:    prdata = '0;
        endcase
    end

    abac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    abac_dp #(
        .AVERAGE_LEN (AVERAGE_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .in_axis     (s_tuser),
        .in_sample   (s_tdata[SAMPLE_W-1:0]),
        .low_pts     (low_reg),
        .high_pts    (high_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_axis    (out_axis),
        .out_average (out_average),
        .out_centi_g (out_centi_g),
        .out_updated (out_updated),
        .out_error   (out_error)
    );

    assign m_tdata = {3'b0, out_centi_g, out_average};
    assign m_tuser = {out_error, out_updated, out_axis};

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_stat.div_busy)
        else $error("divider busy while taking a new item");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_error |-> out_centi_g == '0)
        else $error("calibration error with nonzero centi_g");

    a_centi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_centi_g <= $signed(CENTI_W'(CENTI_LIMIT)))
                  && (out_centi_g >= -$signed(CENTI_W'(CENTI_LIMIT))))
        else $error("centi_g outside calibrated range");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> !m_tvalid || m_tready)
        else $error("result overwritten before it was taken");

endmodule
